FILE: sv/stack_machine_execute_unit_assert.svh
// Assertion macros shared by the checker of the stack machine execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// Checked only while reset is released.
`define SMEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, also while reset is held.
`define SMEU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/smeu_pkg.sv
// Types and codes shared by the stack machine execute unit modules.
`timescale 1ns / 1ps
`default_nettype none

package smeu_pkg;

  localparam logic [4:0] OP_PUSH   = 5'd0;
  localparam logic [4:0] OP_SWAP   = 5'd1;
  localparam logic [4:0] OP_DUP    = 5'd2;
  localparam logic [4:0] OP_DROP   = 5'd3;
  localparam logic [4:0] OP_OVER   = 5'd4;
  localparam logic [4:0] OP_ROT    = 5'd5;
  localparam logic [4:0] OP_ROTINV = 5'd6;
  localparam logic [4:0] OP_TOR    = 5'd7;
  localparam logic [4:0] OP_RFROM  = 5'd8;
  localparam logic [4:0] OP_ADD    = 5'd9;
  localparam logic [4:0] OP_MUL    = 5'd10;
  localparam logic [4:0] OP_SUB    = 5'd11;
  localparam logic [4:0] OP_DIV    = 5'd12;
  localparam logic [4:0] OP_LT     = 5'd13;
  localparam logic [4:0] OP_GT     = 5'd14;
  localparam logic [4:0] OP_LE     = 5'd15;
  localparam logic [4:0] OP_GE     = 5'd16;
  localparam logic [4:0] OP_EQ     = 5'd17;
  localparam logic [4:0] OP_NE     = 5'd18;
  localparam logic [4:0] OP_FETCH  = 5'd19;
  localparam logic [4:0] OP_STORE  = 5'd20;

  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_DUNDER  = 3'd1;
  localparam logic [2:0] ERR_DOVER   = 3'd2;
  localparam logic [2:0] ERR_RUNDER  = 3'd3;
  localparam logic [2:0] ERR_ROVER   = 3'd4;
  localparam logic [2:0] ERR_DIVZERO = 3'd5;
  localparam logic [2:0] ERR_BADADDR = 3'd6;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [31:0] literal;
  } in_word_t;

  typedef struct packed {
    logic [31:0] top_value;
    logic [4:0]  data_depth;
    logic [3:0]  return_depth;
    logic [2:0]  error_code;
  } out_word_t;

  // Word after classification, as it waits in the queue.
  typedef struct packed {
    logic [4:0]  opcode;
    logic [31:0] literal;
    logic [1:0]  needs;
    logic        grows;
    logic        nop;
  } item_t;

endpackage

`default_nettype wire

FILE: sv/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: front end, queue and back end.
// A word accepted into the queue passes to the result register through the back end;
// fetch also goes through the registered memory read, divide through the divider.
// Throughput: one word per cycle for stack and ALU words while the result is not
// stalled; fetch waits for the memory read and divide for the bit-serial divider.
// Reset is synchronous and active low; then in_stall stays high while memory is cleared.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_execute_unit #(
  parameter int DATA_DEPTH   = 16,
  parameter int RETURN_DEPTH = 8,
  parameter int MEM_WORDS    = 1024
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  smeu_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  wire                  out_stall,
  output smeu_pkg::out_word_t  out_word
);

  // The front end classifies each word (stack needs, growth, unused codes) and
  // holds up to two words, so the input side keeps flowing while the back end
  // waits on a stalled result or works through a divide.
  logic            q_valid;
  logic            q_pop;
  logic            clearing;
  smeu_pkg::item_t q_item;

  smeu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // The back end keeps both stacks as shift registers with the top at entry
  // zero, so every operation reads fixed entries. A refused word leaves all
  // state untouched and reports only its error code.
  smeu_back #(
    .DATA_DEPTH   (DATA_DEPTH),
    .RETURN_DEPTH (RETURN_DEPTH),
    .MEM_WORDS    (MEM_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

FILE: sv/smeu_front.sv
// Front end: takes input words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module smeu_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  smeu_pkg::in_word_t   in_word,
  input  wire                  clearing,
  output logic                 q_valid,
  output smeu_pkg::item_t      q_item,
  input  wire                  q_pop
);

  smeu_pkg::item_t q_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;
  smeu_pkg::item_t dec;
  logic            push;

  always_comb begin
    dec.opcode  = in_word.opcode;
    dec.literal = in_word.literal;
    dec.grows   = 1'b0;
    dec.nop     = 1'b0;
    case (in_word.opcode) inside
      smeu_pkg::OP_PUSH, smeu_pkg::OP_RFROM: dec.needs = 2'd0;
      smeu_pkg::OP_DUP, smeu_pkg::OP_DROP, smeu_pkg::OP_TOR,
      smeu_pkg::OP_FETCH: dec.needs = 2'd1;
      smeu_pkg::OP_ROT, smeu_pkg::OP_ROTINV: dec.needs = 2'd3;
      smeu_pkg::OP_SWAP, smeu_pkg::OP_OVER, smeu_pkg::OP_STORE,
      [smeu_pkg::OP_ADD:smeu_pkg::OP_NE]: dec.needs = 2'd2;
      default: begin
        dec.needs = 2'd0;
        dec.nop   = 1'b1;
      end
    endcase
    if (in_word.opcode inside {smeu_pkg::OP_PUSH, smeu_pkg::OP_DUP, smeu_pkg::OP_OVER,
                               smeu_pkg::OP_RFROM}) begin
      dec.grows = 1'b1;
    end
  end

  assign in_stall = (cnt_r == 2'd2) || clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop && q_valid) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

`default_nettype wire

FILE: sv/smeu_div.sv
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module smeu_div (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [31:0] dividend,
  input  wire  [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [31:0] q_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [32:0] sh;
  logic [33:0] diff;
  logic        ge;

  assign sh       = {rem_r, q_r[31]};
  assign diff     = {1'b0, sh} - {2'b00, den_r};
  assign ge       = !diff[33];
  assign done     = busy_r && (cnt_r == 5'd31);
  assign quotient = {q_r[30:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= 32'd0;
      den_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[30:0], ge};
      rem_r <= ge ? diff[31:0] : sh[31:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/smeu_back.sv
// Back end: stacks, word memory, operation sequencing and the result register.
`timescale 1ns / 1ps
`default_nettype none

module smeu_back #(
  parameter int DATA_DEPTH   = 16,
  parameter int RETURN_DEPTH = 8,
  parameter int MEM_WORDS    = 1024
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  input  smeu_pkg::item_t      q_item,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 out_valid,
  input  wire                  out_stall,
  output smeu_pkg::out_word_t  out_word
);

  localparam int DPW = $clog2(DATA_DEPTH + 1);
  localparam int RPW = $clog2(RETURN_DEPTH + 1);
  localparam int AW  = $clog2(MEM_WORDS);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_DIV, S_FETCH} state_t;

  state_t              state_r, state_nxt;
  logic [DPW-1:0]      dp_r, dp_nxt;
  logic [RPW-1:0]      rp_r, rp_nxt;
  logic [31:0]         ds_r  [DATA_DEPTH];
  logic [31:0]         ds_nxt[DATA_DEPTH];
  logic [31:0]         rs_r  [RETURN_DEPTH];
  logic [31:0]         rs_nxt[RETURN_DEPTH];
  logic [31:0]         mem   [MEM_WORDS];
  logic [31:0]         rd_data_r;
  logic [AW-1:0]       clr_r;
  logic                out_valid_r;
  smeu_pkg::out_word_t out_word_r, out_word_nxt;

  logic        slot_free, take, fin, ex_en, div_start, div_done;
  logic [4:0]  ex_op;
  logic [31:0] ex_val, alu, quot, t, s;
  logic [2:0]  err;
  logic [DPW+4:0] dext;
  logic [RPW+3:0] rext;

  assign t         = ds_r[0];
  assign s         = ds_r[1];
  assign clearing  = (state_r == S_CLEAR);
  assign slot_free = !out_valid_r || !out_stall;
  assign take      = (state_r == S_IDLE) && q_valid && slot_free;
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  smeu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (s),
    .divisor  (t),
    .done     (div_done),
    .quotient (quot)
  );

  // Refusal checks in priority order.
  always_comb begin
    err = smeu_pkg::ERR_OK;
    if (q_item.nop) begin
      err = smeu_pkg::ERR_OK;
    end else if (dp_r < DPW'(q_item.needs)) begin
      err = smeu_pkg::ERR_DUNDER;
    end else if (q_item.grows && dp_r >= DPW'(DATA_DEPTH)) begin
      err = smeu_pkg::ERR_DOVER;
    end else if (q_item.opcode == smeu_pkg::OP_RFROM && rp_r == '0) begin
      err = smeu_pkg::ERR_RUNDER;
    end else if (q_item.opcode == smeu_pkg::OP_TOR && rp_r >= RPW'(RETURN_DEPTH)) begin
      err = smeu_pkg::ERR_ROVER;
    end else if (q_item.opcode == smeu_pkg::OP_DIV && t == 32'd0) begin
      err = smeu_pkg::ERR_DIVZERO;
    end else if ((q_item.opcode == smeu_pkg::OP_FETCH ||
                  q_item.opcode == smeu_pkg::OP_STORE) && t >= 32'(MEM_WORDS)) begin
      err = smeu_pkg::ERR_BADADDR;
    end
  end

  always_comb begin
    case (q_item.opcode)
      smeu_pkg::OP_ADD: alu = s + t;
      smeu_pkg::OP_MUL: alu = s * t;
      smeu_pkg::OP_SUB: alu = s - t;
      smeu_pkg::OP_LT:  alu = {31'd0, s < t};
      smeu_pkg::OP_GT:  alu = {31'd0, s > t};
      smeu_pkg::OP_LE:  alu = {31'd0, s <= t};
      smeu_pkg::OP_GE:  alu = {31'd0, s >= t};
      smeu_pkg::OP_EQ:  alu = {31'd0, s == t};
      smeu_pkg::OP_NE:  alu = {31'd0, s != t};
      default:          alu = q_item.literal;
    endcase
  end

  // Sequencing of one word.
  always_comb begin
    state_nxt = state_r;
    fin       = 1'b0;
    ex_en     = 1'b0;
    ex_op     = q_item.opcode;
    ex_val    = alu;
    div_start = 1'b0;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          if (q_item.nop || err != smeu_pkg::ERR_OK) begin
            fin = 1'b1;
          end else if (q_item.opcode == smeu_pkg::OP_DIV) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else if (q_item.opcode == smeu_pkg::OP_FETCH) begin
            state_nxt = S_FETCH;
          end else begin
            ex_en = 1'b1;
            fin   = 1'b1;
          end
        end
      end
      S_DIV: begin
        ex_op  = smeu_pkg::OP_DIV;
        ex_val = quot;
        if (div_done) begin
          ex_en     = 1'b1;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FETCH: begin
        ex_op     = smeu_pkg::OP_FETCH;
        ex_val    = rd_data_r;
        ex_en     = 1'b1;
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Stack updates; entry zero is the top.
  always_comb begin
    ds_nxt = ds_r;
    rs_nxt = rs_r;
    dp_nxt = dp_r;
    rp_nxt = rp_r;
    if (ex_en) begin
      case (ex_op) inside
        smeu_pkg::OP_PUSH, smeu_pkg::OP_DUP, smeu_pkg::OP_OVER, smeu_pkg::OP_RFROM: begin
          for (int i = 1; i < DATA_DEPTH; i++) begin
            ds_nxt[i] = ds_r[i-1];
          end
          case (ex_op)
            smeu_pkg::OP_DUP:   ds_nxt[0] = ds_r[0];
            smeu_pkg::OP_OVER:  ds_nxt[0] = ds_r[1];
            smeu_pkg::OP_RFROM: ds_nxt[0] = rs_r[0];
            default:            ds_nxt[0] = ex_val;
          endcase
          dp_nxt = dp_r + DPW'(1);
          if (ex_op == smeu_pkg::OP_RFROM) begin
            for (int i = 0; i < RETURN_DEPTH - 1; i++) begin
              rs_nxt[i] = rs_r[i+1];
            end
            rp_nxt = rp_r - RPW'(1);
          end
        end
        smeu_pkg::OP_SWAP: begin
          ds_nxt[0] = ds_r[1];
          ds_nxt[1] = ds_r[0];
        end
        smeu_pkg::OP_ROT: begin
          ds_nxt[0] = ds_r[2];
          ds_nxt[1] = ds_r[0];
          ds_nxt[2] = ds_r[1];
        end
        smeu_pkg::OP_ROTINV: begin
          ds_nxt[0] = ds_r[1];
          ds_nxt[1] = ds_r[2];
          ds_nxt[2] = ds_r[0];
        end
        smeu_pkg::OP_DROP, smeu_pkg::OP_TOR: begin
          for (int i = 0; i < DATA_DEPTH - 1; i++) begin
            ds_nxt[i] = ds_r[i+1];
          end
          dp_nxt = dp_r - DPW'(1);
          if (ex_op == smeu_pkg::OP_TOR) begin
            for (int i = 1; i < RETURN_DEPTH; i++) begin
              rs_nxt[i] = rs_r[i-1];
            end
            rs_nxt[0] = ds_r[0];
            rp_nxt    = rp_r + RPW'(1);
          end
        end
        [smeu_pkg::OP_ADD:smeu_pkg::OP_NE]: begin
          for (int i = 1; i < DATA_DEPTH - 1; i++) begin
            ds_nxt[i] = ds_r[i+1];
          end
          ds_nxt[0] = ex_val;
          dp_nxt    = dp_r - DPW'(1);
        end
        smeu_pkg::OP_FETCH: begin
          ds_nxt[0] = ex_val;
        end
        smeu_pkg::OP_STORE: begin
          for (int i = 0; i < DATA_DEPTH - 2; i++) begin
            ds_nxt[i] = ds_r[i+2];
          end
          dp_nxt = dp_r - DPW'(2);
        end
        default: begin
          dp_nxt = dp_r;
        end
      endcase
    end
  end

  always_comb begin
    dext = {5'd0, dp_nxt};
    rext = {4'd0, rp_nxt};
    out_word_nxt.top_value    = (dp_nxt != '0) ? ds_nxt[0] : 32'd0;
    out_word_nxt.data_depth   = dext[4:0];
    out_word_nxt.return_depth = rext[3:0];
    out_word_nxt.error_code   = err;
    if (state_r != S_IDLE) begin
      out_word_nxt.error_code = smeu_pkg::ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      dp_r        <= '0;
      rp_r        <= '0;
      clr_r       <= '0;
    end else begin
      state_r <= state_nxt;
      dp_r    <= dp_nxt;
      rp_r    <= rp_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (fin) begin
        out_valid_r <= 1'b1;
        out_word_r  <= out_word_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ds_r <= ds_nxt;
    rs_r <= rs_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      mem[clr_r] <= 32'd0;
    end else if (ex_en && ex_op == smeu_pkg::OP_STORE) begin
      mem[t[AW-1:0]] <= s;
    end
    rd_data_r <= mem[t[AW-1:0]];
  end

endmodule

`default_nettype wire

FILE: sv/smeu_checker.sv
// Port checker for the stack machine execute unit and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "stack_machine_execute_unit_assert.svh"

module smeu_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input smeu_pkg::in_word_t  in_word,
  input wire                 out_valid,
  input wire                 out_stall,
  input smeu_pkg::out_word_t out_word
);

  `SMEU_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid && in_stall, "no quiet state after reset")
  `SMEU_ASSERT_RST(a_clear_stall, !rst_n ##1 rst_n |=> in_stall, "input open during memory clear")
  `SMEU_ASSERT(a_err_range, out_valid |-> out_word.error_code <= smeu_pkg::ERR_BADADDR, "bad error code")
  `SMEU_ASSERT(a_hold_valid, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `SMEU_ASSERT(a_hold_input, in_valid && in_stall |=> in_valid && $stable(in_word), "input word changed while stalled")

endmodule

bind stack_machine_execute_unit smeu_checker u_checker (.*);

`default_nettype wire

FILE: verif/stack_machine_execute_unit_tb.sv
// Self-checking testbench for the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_execute_unit_tb;

  localparam int DATA_DEPTH   = 16;
  localparam int RETURN_DEPTH = 8;
  localparam int MEM_WORDS    = 1024;
  localparam int CYCLE_LIMIT  = 400000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  smeu_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  smeu_pkg::out_word_t out_word;

  stack_machine_execute_unit #(
    .DATA_DEPTH(DATA_DEPTH),
    .RETURN_DEPTH(RETURN_DEPTH),
    .MEM_WORDS(MEM_WORDS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always #5 clk = ~clk;

  // Words waiting to be sent, and the result words the shadow machine predicts.
  smeu_pkg::in_word_t  program_words[$];
  smeu_pkg::out_word_t expected_results[$];

  // Shadow copy of the machine state, updated as each word is accepted.
  logic [31:0] shadow_data[DATA_DEPTH];
  logic [31:0] shadow_ret[RETURN_DEPTH];
  logic [31:0] shadow_mem[MEM_WORDS];
  int unsigned shadow_dp;
  int unsigned shadow_rp;

  // Idle percentages for each side; changed by the initial block between phases.
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 79;

  int unsigned error_count;
  int unsigned results_seen;
  int unsigned words_sent;
  int unsigned cycle_count;
  int unsigned err_hist[8];

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Executes one word on the shadow machine and returns the result word the
  // block should produce. A refused word leaves the state untouched.
  function automatic smeu_pkg::out_word_t execute_word(input smeu_pkg::in_word_t w);
    smeu_pkg::out_word_t res;
    logic [2:0]          err;
    logic [31:0]         t, s, r;
    int unsigned         need;
    logic                push;
    int unsigned         d;
    d    = shadow_dp;
    err  = smeu_pkg::ERR_OK;
    need = 0;
    push = (w.opcode == smeu_pkg::OP_PUSH) || (w.opcode == smeu_pkg::OP_DUP) ||
           (w.opcode == smeu_pkg::OP_OVER) || (w.opcode == smeu_pkg::OP_RFROM);
    case (w.opcode)
      smeu_pkg::OP_SWAP, smeu_pkg::OP_OVER, smeu_pkg::OP_STORE: need = 2;
      smeu_pkg::OP_DUP, smeu_pkg::OP_DROP, smeu_pkg::OP_TOR, smeu_pkg::OP_FETCH: need = 1;
      smeu_pkg::OP_ROT, smeu_pkg::OP_ROTINV: need = 3;
      default: need = (w.opcode inside {[smeu_pkg::OP_ADD:smeu_pkg::OP_NE]}) ? 2 : 0;
    endcase
    t = (d >= 1) ? shadow_data[d-1] : '0;
    s = (d >= 2) ? shadow_data[d-2] : '0;
    if (w.opcode > smeu_pkg::OP_STORE) err = smeu_pkg::ERR_OK;
    else if (d < need) err = smeu_pkg::ERR_DUNDER;
    else if (push && d >= DATA_DEPTH) err = smeu_pkg::ERR_DOVER;
    else if (w.opcode == smeu_pkg::OP_RFROM && shadow_rp == 0) err = smeu_pkg::ERR_RUNDER;
    else if (w.opcode == smeu_pkg::OP_TOR && shadow_rp >= RETURN_DEPTH)
      err = smeu_pkg::ERR_ROVER;
    else if (w.opcode == smeu_pkg::OP_DIV && t == 0) err = smeu_pkg::ERR_DIVZERO;
    else if ((w.opcode == smeu_pkg::OP_FETCH || w.opcode == smeu_pkg::OP_STORE) &&
             t >= MEM_WORDS)
      err = smeu_pkg::ERR_BADADDR;
    else begin
      case (w.opcode)
        smeu_pkg::OP_PUSH: begin shadow_data[d] = w.literal; shadow_dp = d + 1; end
        smeu_pkg::OP_SWAP: begin shadow_data[d-1] = s; shadow_data[d-2] = t; end
        smeu_pkg::OP_DUP: begin shadow_data[d] = t; shadow_dp = d + 1; end
        smeu_pkg::OP_DROP: shadow_dp = d - 1;
        smeu_pkg::OP_OVER: begin shadow_data[d] = s; shadow_dp = d + 1; end
        smeu_pkg::OP_ROT: begin
          r = shadow_data[d-3];
          shadow_data[d-3] = s; shadow_data[d-2] = t; shadow_data[d-1] = r;
        end
        smeu_pkg::OP_ROTINV: begin
          r = shadow_data[d-3];
          shadow_data[d-3] = t; shadow_data[d-2] = r; shadow_data[d-1] = s;
        end
        smeu_pkg::OP_TOR: begin
          shadow_ret[shadow_rp] = t;
          shadow_rp++;
          shadow_dp = d - 1;
        end
        smeu_pkg::OP_RFROM: begin
          shadow_rp--;
          shadow_data[d] = shadow_ret[shadow_rp];
          shadow_dp = d + 1;
        end
        smeu_pkg::OP_FETCH: shadow_data[d-1] = shadow_mem[t];
        smeu_pkg::OP_STORE: begin shadow_mem[t] = s; shadow_dp = d - 2; end
        smeu_pkg::OP_ADD, smeu_pkg::OP_MUL, smeu_pkg::OP_SUB, smeu_pkg::OP_DIV,
        smeu_pkg::OP_LT, smeu_pkg::OP_GT, smeu_pkg::OP_LE, smeu_pkg::OP_GE,
        smeu_pkg::OP_EQ, smeu_pkg::OP_NE: begin
          case (w.opcode)
            smeu_pkg::OP_ADD: r = s + t;
            smeu_pkg::OP_MUL: r = s * t;
            smeu_pkg::OP_SUB: r = s - t;
            smeu_pkg::OP_DIV: r = s / t;
            smeu_pkg::OP_LT:  r = {31'd0, s < t};
            smeu_pkg::OP_GT:  r = {31'd0, s > t};
            smeu_pkg::OP_LE:  r = {31'd0, s <= t};
            smeu_pkg::OP_GE:  r = {31'd0, s >= t};
            smeu_pkg::OP_EQ:  r = {31'd0, s == t};
            default: r = {31'd0, s != t};
          endcase
          shadow_data[d-2] = r;
          shadow_dp = d - 1;
        end
        default: ;
      endcase
    end
    res.top_value    = (shadow_dp > 0) ? shadow_data[shadow_dp-1] : '0;
    res.data_depth   = shadow_dp[4:0];
    res.return_depth = shadow_rp[3:0];
    res.error_code   = err;
    return res;
  endfunction

  // Driver: a word stays on the bus until it is taken. The next word, or an
  // idle cycle, is chosen only after the current one has been accepted, so
  // in_valid never falls while a word is pending and no edge sees two
  // assignments to it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(execute_word(in_word));
        err_hist[expected_results[$].error_code]++;
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (program_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word  <= program_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word against the oldest prediction,
  // then decides the stall for the next edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          smeu_pkg::out_word_t e;
          e = expected_results.pop_front();
          if (out_word.top_value !== e.top_value)
            report_mismatch($sformatf("top_value %h, expected %h",
                                      out_word.top_value, e.top_value));
          if (out_word.data_depth !== e.data_depth)
            report_mismatch($sformatf("data_depth %0d, expected %0d",
                                      out_word.data_depth, e.data_depth));
          if (out_word.return_depth !== e.return_depth)
            report_mismatch($sformatf("return_depth %0d, expected %0d",
                                      out_word.return_depth, e.return_depth));
          if (out_word.error_code !== e.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      out_word.error_code, e.error_code));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: the slowest correct run (memory clearing, many divides under
  // heavy stall) stays far below this limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic smeu_pkg::in_word_t mk(input logic [4:0] op, input logic [31:0] lit);
    smeu_pkg::in_word_t w;
    w.opcode  = op;
    w.literal = lit;
    return w;
  endfunction

  // Random address: mostly a small window so stores and fetches meet, at times
  // anywhere in memory, and at times out of range.
  function automatic logic [31:0] rand_addr();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 60) return $urandom_range(15);
    if (k < 85) return $urandom_range(MEM_WORDS - 1);
    if (k < 92) return MEM_WORDS;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(7);
      3: return 32'h8000_0000 | $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // Queues one random word. Operands are mostly built as well-formed
  // sequences (push operands then operate); the rest is raw noise that also
  // drives the stacks into underflow and overflow.
  task automatic queue_random_word();
    int unsigned k;
    logic [4:0]  op;
    k = $urandom_range(99);
    if (k < 30) begin
      program_words.push_back(mk(smeu_pkg::OP_PUSH, rand_value()));
    end else if (k < 45) begin
      // Memory access with a freshly pushed address.
      program_words.push_back(mk(smeu_pkg::OP_PUSH, rand_addr()));
      program_words.push_back(mk($urandom_range(1) ? smeu_pkg::OP_FETCH : smeu_pkg::OP_STORE,
                                 $urandom));
    end else if (k < 52) begin
      program_words.push_back(mk(smeu_pkg::OP_PUSH,
                                 $urandom_range(3) == 0 ? 32'd0 : rand_value()));
      program_words.push_back(mk(smeu_pkg::OP_DIV, $urandom));
    end else if (k < 60) begin
      // Drain toward empty so depths swing over the whole range.
      repeat ($urandom_range(6)) program_words.push_back(mk(smeu_pkg::OP_DROP, $urandom));
    end else if (k < 95) begin
      op = 5'($urandom_range(smeu_pkg::OP_NE));
      if (op == smeu_pkg::OP_DIV) op = smeu_pkg::OP_ADD;
      program_words.push_back(mk(op, $urandom));
    end else begin
      // Unused opcodes and anything else.
      program_words.push_back(mk(5'($urandom_range(31)), $urandom));
    end
  endtask

  task automatic wait_drained();
    while (program_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int unsigned i;
    for (i = 0; i < DATA_DEPTH; i++) shadow_data[i] = '0;
    for (i = 0; i < RETURN_DEPTH; i++) shadow_ret[i] = '0;
    for (i = 0; i < MEM_WORDS; i++) shadow_mem[i] = '0;
    shadow_dp = 0;
    shadow_rp = 0;

    // Directed part: underflow on empty stacks, extremes of the literal,
    // every operation, divide by zero, a bad address, an unused opcode.
    program_words.push_back(mk(smeu_pkg::OP_DROP, '0));
    program_words.push_back(mk(smeu_pkg::OP_RFROM, '0));
    program_words.push_back(mk(smeu_pkg::OP_PUSH, 32'hFFFF_FFFF));
    program_words.push_back(mk(smeu_pkg::OP_PUSH, 32'd0));
    program_words.push_back(mk(smeu_pkg::OP_DIV, '0));
    program_words.push_back(mk(smeu_pkg::OP_PUSH, 32'd3));
    program_words.push_back(mk(smeu_pkg::OP_SWAP, '0));
    program_words.push_back(mk(smeu_pkg::OP_OVER, '0));
    program_words.push_back(mk(smeu_pkg::OP_ROT, '0));
    program_words.push_back(mk(smeu_pkg::OP_ROTINV, '0));
    program_words.push_back(mk(smeu_pkg::OP_DUP, '0));
    program_words.push_back(mk(smeu_pkg::OP_TOR, '0));
    program_words.push_back(mk(smeu_pkg::OP_RFROM, '0));
    program_words.push_back(mk(smeu_pkg::OP_ADD, '0));
    program_words.push_back(mk(smeu_pkg::OP_MUL, '0));
    program_words.push_back(mk(smeu_pkg::OP_PUSH, 32'd7));
    program_words.push_back(mk(smeu_pkg::OP_SUB, '0));
    program_words.push_back(mk(smeu_pkg::OP_PUSH, MEM_WORDS - 1));
    program_words.push_back(mk(smeu_pkg::OP_STORE, '0));
    program_words.push_back(mk(smeu_pkg::OP_PUSH, MEM_WORDS));
    program_words.push_back(mk(smeu_pkg::OP_FETCH, '0));
    program_words.push_back(mk(5'd31, 32'hFFFF_FFFF));
    for (i = smeu_pkg::OP_LT; i <= smeu_pkg::OP_NE; i++) begin
      program_words.push_back(mk(smeu_pkg::OP_DUP, '0));
      program_words.push_back(mk(smeu_pkg::OP_DUP, '0));
      program_words.push_back(mk(i[4:0], '0));
    end
    // Fill both stacks past their limits, then empty them again.
    repeat (DATA_DEPTH + 1) program_words.push_back(mk(smeu_pkg::OP_PUSH, $urandom));
    repeat (RETURN_DEPTH + 1) program_words.push_back(mk(smeu_pkg::OP_TOR, '0));
    repeat (RETURN_DEPTH + 1) program_words.push_back(mk(smeu_pkg::OP_RFROM, '0));
    repeat (DATA_DEPTH + 1) program_words.push_back(mk(smeu_pkg::OP_DROP, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Random part in three phases with different idle patterns.
    for (int ph = 0; ph < 3; ph++) begin
      while (program_words.size() < 380) queue_random_word();
      while (program_words.size() > 0 || in_valid) @(posedge clk);
      if (ph == 0) begin
        send_idle_pct = 79;
        recv_idle_pct = 25;
      end else if (ph == 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
    wait_drained();

    $display("Sent %0d words, checked %0d result words.", words_sent, results_seen);
    $display({"Error codes seen: ok %0d, underflow %0d, overflow %0d, ret under %0d, ",
              "ret over %0d, divide by zero %0d, bad address %0d."},
             err_hist[0], err_hist[1], err_hist[2], err_hist[3],
             err_hist[4], err_hist[5], err_hist[6]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
